/* rtl/bpts_pkg.sv */
// Shared constants, command codes and the cell control type of the task scheduler.
package bpts_pkg;

    localparam int TASKS_DEF = 32;
    localparam int SLOT_W    = 5;
    localparam int CMD_W     = 3;
    localparam int TICK_W    = 32;
    localparam int LOCK_W    = 8;

    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    localparam logic [CMD_W-1:0] CMD_ACTIVATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELAY    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCK     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNLOCK   = 3'd4;

    typedef struct packed {
        logic              activate;
        logic              delay;
        logic              tick;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] ticks;
    } t_cell_ctl;

endpackage

/* rtl/bpts_cmd_if.sv */
// Command channel of the task scheduler: valid, ready and the command word.
interface bpts_cmd_if
    import bpts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] task_id;
    logic [TICK_W-1:0] ticks;

    modport source (output valid, command, task_id, ticks, input ready);
    modport sink (input valid, command, task_id, ticks, output ready);
endinterface

/* rtl/bpts_res_if.sv */
// Result channel of the task scheduler: valid, ready and the result word.
interface bpts_res_if
    import bpts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              switch_now;
    logic [SLOT_W-1:0] next_task;
    logic [LOCK_W-1:0] lock_count;

    modport source (output valid, switch_now, next_task, lock_count, input ready);
    modport sink (input valid, switch_now, next_task, lock_count, output ready);
endinterface

/* rtl/bpts_cell.sv */
// One task slot: delay counter, ready bit and its link in the priority chain.
module bpts_cell
    import bpts_pkg::*;
#(
    parameter int TASKS = TASKS_DEF,
    parameter int SLOT  = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_lower,
    output logic      o_lower,
    output logic      o_grant
);

    logic [TICK_W-1:0] r_count;
    logic              r_ready;
    logic              w_hit;

    assign w_hit = (i_ctl.slot == SLOT_W'(SLOT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ready <= (SLOT == TASKS - 1);
        end else if (i_ctl.activate && w_hit) begin
            r_count <= '0;
            r_ready <= 1'b1;
        end else if (i_ctl.delay && w_hit) begin
            r_count <= i_ctl.ticks;
            r_ready <= 1'b0;
        end else if (i_ctl.tick) begin
            if (r_count != '0) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_ready <= 1'b1;
            end
        end
    end

    // A slot wins when it is ready and no lower slot is.
    assign o_grant = r_ready && !i_lower;
    assign o_lower = r_ready || i_lower;

endmodule

/* rtl/bitmap_priority_task_scheduler.sv */
// Top level of the bitmap priority task scheduler with tick delays.
// The scheduler takes a new command word only after the result of the last
// one is registered: at the edge that accepts a command, the row of slot
// cells applies activate, delay or tick and the lock depth is updated; then
// the ready bits ripple through the cells' priority chain, the lowest ready
// slot is chosen, and the result word is registered once the output register
// is free. A result that waits on the output holds back the choice of the next command.
// An empty ready bitmap selects the last slot, which serves as the idle task.
module bitmap_priority_task_scheduler
    import bpts_pkg::*;
#(
    parameter int TASKS = TASKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpts_cmd_if.sink   i_cmd,
    bpts_res_if.source o_res
);

    logic              r_busy;
    logic              r_run;
    logic [SLOT_W-1:0] r_running;
    logic [LOCK_W-1:0] r_lock;
    logic              r_out_valid;
    logic              r_sw;
    logic [SLOT_W-1:0] r_next;
    logic [LOCK_W-1:0] r_lock_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_switch;
    logic [SLOT_W-1:0] w_pick;
    logic [TASKS:0]    w_lower;
    logic [TASKS-1:0]  w_grant;
    t_cell_ctl         w_ctl;

    assign i_cmd.ready = !r_busy;
    assign w_accept    = i_cmd.valid && !r_busy;
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        w_ctl.activate = w_accept && (i_cmd.command == CMD_ACTIVATE);
        w_ctl.delay    = w_accept && (i_cmd.command == CMD_DELAY);
        w_ctl.tick     = w_accept && (i_cmd.command == CMD_TICK);
        w_ctl.slot     = (i_cmd.command == CMD_ACTIVATE) ? i_cmd.task_id : r_running;
        w_ctl.ticks    = i_cmd.ticks;
    end

    assign w_lower[0] = 1'b0;

    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        bpts_cell #(
            .TASKS (TASKS),
            .SLOT  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_lower (w_lower[g]),
            .o_lower (w_lower[g+1]),
            .o_grant (w_grant[g])
        );
    end

    always_comb begin
        w_pick = SLOT_W'(TASKS - 1);
        for (int i = 0; i < TASKS; i++) begin
            if (w_grant[i]) begin
                w_pick = SLOT_W'(i);
            end
        end
    end

    assign w_switch = r_run && (w_pick != r_running);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_run       <= 1'b0;
            r_running   <= SLOT_W'(TASKS - 1);
            r_lock      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_run  <= (((i_cmd.command == CMD_DELAY) || (i_cmd.command == CMD_TICK))
                           && (r_lock == '0))
                          || ((i_cmd.command == CMD_UNLOCK) && (r_lock == LOCK_W'(1)));
                case (i_cmd.command)
                    CMD_LOCK: begin
                        if (r_lock != LOCK_MAX) begin
                            r_lock <= r_lock + 1'b1;
                        end
                    end
                    CMD_UNLOCK: begin
                        if (r_lock != '0) begin
                            r_lock <= r_lock - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_busy && w_out_free) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                if (w_switch) begin
                    r_running <= w_pick;
                end
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_out_free) begin
            r_sw       <= w_switch;
            r_next     <= w_switch ? w_pick : r_running;
            r_lock_out <= r_lock;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.switch_now = r_sw;
    assign o_res.next_task  = r_next;
    assign o_res.lock_count = r_lock_out;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the bitmap priority task scheduler with tick delays.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpts_pkg::*;

    localparam int TASKS        = TASKS_DEF;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CMD_W-1:0] CMD_RESERVED_LO = CMD_UNLOCK + 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVED_HI = '1;
    localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(TASKS - 1);

    typedef struct packed {
        logic              switch_now;
        logic [SLOT_W-1:0] next_task;
        logic [LOCK_W-1:0] lock_count;
    } t_sched_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpts_cmd_if cmd_ch ();
    bpts_res_if res_ch ();

    bitmap_priority_task_scheduler #(.TASKS(TASKS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    logic [TICK_W-1:0] slot_delay [TASKS];
    logic [TASKS-1:0]  ready_bits;
    logic [LOCK_W-1:0] lock_level;
    logic [SLOT_W-1:0] current_slot;

    t_sched_word expected_words[$];
    int          fault_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic reschedule();
        logic [SLOT_W-1:0] pick;
        pick = IDLE_SLOT;
        if (lock_level != '0) return 1'b0;
        for (int s = TASKS - 1; s >= 0; s--) begin
            if (ready_bits[s]) pick = SLOT_W'(s);
        end
        if (pick == current_slot) return 1'b0;
        current_slot = pick;
        return 1'b1;
    endfunction

    function automatic void predict_schedule(input logic [CMD_W-1:0] cmd,
                                             input logic [SLOT_W-1:0] id,
                                             input logic [TICK_W-1:0] ticks);
        logic        switched;
        t_sched_word word;
        switched = 1'b0;
        case (cmd)
            CMD_ACTIVATE: begin
                if (id < TASKS) begin
                    slot_delay[id] = '0;
                    ready_bits[id] = 1'b1;
                end
            end
            CMD_DELAY: begin
                slot_delay[current_slot] = ticks;
                ready_bits[current_slot] = 1'b0;
                switched = reschedule();
            end
            CMD_TICK: begin
                for (int s = 0; s < TASKS; s++) begin
                    if (slot_delay[s] != '0) slot_delay[s] = slot_delay[s] - 1'b1;
                    else ready_bits[s] = 1'b1;
                end
                switched = reschedule();
            end
            CMD_LOCK: begin
                if (lock_level != LOCK_MAX) lock_level = lock_level + 1'b1;
            end
            CMD_UNLOCK: begin
                if (lock_level != '0) begin
                    lock_level = lock_level - 1'b1;
                    if (lock_level == '0) switched = reschedule();
                end
            end
            default: ;
        endcase
        word.switch_now = switched;
        word.next_task  = current_slot;
        word.lock_count = lock_level;
        expected_words.push_back(word);
    endfunction

    always @(posedge i_clk) begin
        t_sched_word want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected word: sw=%0d task=%0d lock=%0d",
                                 res_ch.switch_now, res_ch.next_task, res_ch.lock_count);
                end else begin
                    want = expected_words.pop_front();
                    if (res_ch.switch_now !== want.switch_now ||
                        res_ch.next_task !== want.next_task ||
                        res_ch.lock_count !== want.lock_count) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display("mismatch: expected sw=%0d task=%0d lock=%0d",
                                     want.switch_now, want.next_task, want.lock_count,
                                     ", got sw=%0d task=%0d lock=%0d",
                                     res_ch.switch_now, res_ch.next_task,
                                     res_ch.lock_count);
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                predict_schedule(cmd_ch.command, cmd_ch.task_id, cmd_ch.ticks);
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] id,
                             input logic [TICK_W-1:0] ticks);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.task_id <= id;
        cmd_ch.ticks   <= ticks;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic test_directed_commands();
        send_word(CMD_RESERVED_LO, 5'd31, 32'hFFFF_FFFF);
        send_word(CMD_RESERVED_LO + 3'd1, 5'd0, 32'h0);
        send_word(CMD_RESERVED_HI, 5'd21, 32'h5555_AAAA);
        send_word(CMD_DELAY, 5'd0, 32'hFFFF_FFFF);
        send_word(CMD_ACTIVATE, 5'd21, 32'h0);
        send_word(CMD_ACTIVATE, 5'd10, 32'hFFFF_FFFF);
        send_word(CMD_DELAY, 5'd0, 32'h0);
        send_word(CMD_LOCK, 5'd0, 32'h0);
        send_word(CMD_ACTIVATE, 5'd0, 32'h0);
        send_word(CMD_DELAY, 5'd31, 32'd3);
        send_word(CMD_UNLOCK, 5'd0, 32'h0);
        send_word(CMD_UNLOCK, 5'd0, 32'h0);
        send_word(CMD_DELAY, 5'd0, 32'd2);
        send_word(CMD_TICK, 5'd0, 32'h0);
        send_word(CMD_TICK, 5'd31, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 5'd0, 32'h0);
        send_word(CMD_ACTIVATE, IDLE_SLOT, 32'h0);
        send_word(CMD_DELAY, 5'd0, 32'd1);
        send_word(CMD_TICK, 5'd0, 32'h0);
    endtask

    task automatic test_lock_saturation();
        repeat (int'(LOCK_MAX) + 4)
            send_word(CMD_LOCK, SLOT_W'($urandom_range(TASKS - 1)), $urandom);
        send_word(CMD_TICK, 5'd0, 32'h0);
        send_word(CMD_DELAY, 5'd0, 32'd4);
        send_word(CMD_ACTIVATE, 5'd3, 32'h0);
        repeat (int'(LOCK_MAX) + 4)
            send_word(CMD_UNLOCK, SLOT_W'($urandom_range(TASKS - 1)), $urandom);
    endtask

    task automatic test_random_traffic(input int count);
        logic [CMD_W-1:0]  cmd;
        logic [TICK_W-1:0] ticks;
        int                pick;
        repeat (count) begin
            pick  = $urandom_range(99);
            ticks = $urandom;
            if (pick < 30) begin
                cmd = CMD_ACTIVATE;
            end else if (pick < 50) begin
                cmd = CMD_DELAY;
                case ($urandom_range(9))
                    7, 8:    ticks = $urandom;
                    9:       ticks = '1;
                    default: ticks = TICK_W'($urandom_range(6));
                endcase
            end else if (pick < 80) begin
                cmd = CMD_TICK;
            end else if (pick < 88) begin
                cmd = (lock_level < 3) ? CMD_LOCK : CMD_UNLOCK;
            end else if (pick < 96) begin
                cmd = CMD_UNLOCK;
            end else begin
                cmd = CMD_W'($urandom_range(CMD_RESERVED_HI, CMD_RESERVED_LO));
            end
            send_word(cmd, SLOT_W'($urandom_range(TASKS - 1)), ticks);
        end
    endtask

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.task_id = '0;
        cmd_ch.ticks   = '0;
        res_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        for (int s = 0; s < TASKS; s++) slot_delay[s] = '0;
        ready_bits   = '0;
        ready_bits[TASKS - 1] = 1'b1;
        lock_level   = '0;
        current_slot = IDLE_SLOT;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 65;
        test_directed_commands();
        test_random_traffic(340);

        send_idle_pct = 65;
        recv_idle_pct = 28;
        test_lock_saturation();
        test_random_traffic(340);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(340);

        cmd_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
